@@ hdl/dbvv_pkg.sv @@
// Shared types and constants for the depth buffer vertex visibility unit.
// No dependencies; used by the top level.
`default_nettype none

package dbvv_pkg;

  // Input item actions.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TEST  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Arithmetic widths.
  localparam int unsigned PROD_W     = 64;  // full 32x32 product
  localparam int unsigned TERM_W     = 48;  // product after the Q16 scale-down
  localparam int unsigned CLIP_W     = 50;  // clip component
  localparam int unsigned NUM_W      = 51;  // magnitude of c + w
  localparam int unsigned DEN_W      = 51;  // 2|w|
  localparam int unsigned SCALE_W    = 17;  // window size or depth scale
  localparam int unsigned DIVIDEND_W = NUM_W + SCALE_W;
  localparam int unsigned DCNT_W     = 7;   // enough to count dividend bits
  localparam int unsigned ZQ_W       = 19;  // signed window depth with extra range
  localparam int unsigned CNT_W      = 24;

  localparam logic [SCALE_W-1:0]   DEPTH_SCALE = 17'd65536;
  localparam logic [ZQ_W-2:0]      ZQ_LIMIT    = 18'd131072;
  localparam logic [19:0]          DEPTH_TOL   = 20'd983;
  localparam logic [CNT_W-1:0]     COUNTER_MAX = 24'hFFFFFF;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECKW,
    ST_NUM,
    ST_SCALE,
    ST_DIV,
    ST_POST,
    ST_NB,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [15:0]        depth_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } in_item_t;

  typedef struct packed {
    logic               is_visible;
    logic               is_outside;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [15:0]        window_depth;
    logic [23:0]        visible_total;
    logic [23:0]        outside_total;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/dbvv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dbvv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/depth_buffer_vertex_visibility_unit.sv @@
// Depth buffer vertex visibility unit: depth image store and vertex tester.
// Depends on dbvv_pkg and dbvv_ram.
// Load and clear items are handled in the idle state. A test item is accepted,
// runs the transform on the shared 32x32 multiplier, checks w and, unless w is
// zero, makes three passes of the shared restoring divider (68 quotient bits
// each) and a neighborhood scan on the single depth read port; the result is
// then issued once the output is free. New items are accepted only when idle.
// Reset (rst, synchronous) clears the sequencer, counters and matrix; the
// depth memory is not cleared and holds garbage until written.
`default_nettype none

module depth_buffer_vertex_visibility_unit
  import dbvv_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 256
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  input  wire logic      cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned STORE_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned XW          = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW          = $clog2(SCREEN_HEIGHT);

  state_t state, state_next;

  // Matrix, row-major, 4 elements per row.
  logic signed [31:0] mat [16];

  // Vertex and transform registers.
  logic signed [31:0]     vx, vy, vz;
  logic signed [PROD_W-1:0] prod;
  logic signed [CLIP_W-1:0] clip [4];
  logic [1:0]             row, col;

  // Divider registers.
  logic [1:0]             div_sel;
  logic [NUM_W-1:0]       num;
  logic                   neg;
  logic [DEN_W-1:0]       den;
  logic [DIVIDEND_W-1:0]  dvd;
  logic [DEN_W-1:0]       rem;
  logic [DCNT_W-1:0]      div_cnt;

  // Results under construction.
  logic signed [15:0]     sx, sy;
  logic signed [ZQ_W-1:0] zq;
  logic [15:0]            wd;
  logic                   visible, outside;
  logic [1:0]             nb_dx, nb_dy;

  logic [CNT_W-1:0]       visible_count, outside_count;

  // Control decode.
  logic in_fire, out_free;
  logic ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [15:0] ram_rd_data;
  logic pixel_ok;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pixel_ok = (12'(in_item.pixel_x) < 12'(SCREEN_WIDTH)) &&
                    (12'(in_item.pixel_y) < 12'(SCREEN_HEIGHT));

  // Multiplier operand select.
  logic signed [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = mat[{row, col}];
    case (col)
      2'd0:    mul_b = vx;
      2'd1:    mul_b = vy;
      default: mul_b = vz;
    endcase
  end

  // Product scaled down by 2^16, truncated toward zero.
  logic signed [TERM_W-1:0] term;
  always_comb begin
    term = TERM_W'(prod >>> 16);
    if (prod[PROD_W-1] && (prod[15:0] != 16'd0)) begin
      term = term + TERM_W'(1);
    end
  end

  // Numerator c + w for the current division.
  logic signed [CLIP_W-1:0] num_c;
  logic signed [NUM_W-1:0]  num_sum;
  logic [SCALE_W-1:0]       scale;
  always_comb begin
    case (div_sel)
      2'd0: begin
        num_c = clip[0];
        scale = SCALE_W'(SCREEN_WIDTH);
      end
      2'd1: begin
        num_c = clip[1];
        scale = SCALE_W'(SCREEN_HEIGHT);
      end
      default: begin
        num_c = clip[2];
        scale = DEPTH_SCALE;
      end
    endcase
    num_sum = NUM_W'(num_c) + NUM_W'(clip[3]);
  end

  // One restoring divider step.
  logic [DEN_W:0] trial, trial_sub;
  logic           qbit;
  always_comb begin
    trial     = {rem, dvd[DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, den};
    qbit      = (trial >= {1'b0, den});
  end

  // Quotient post-processing.
  logic [DIVIDEND_W-1:0] q;
  logic signed [15:0]    q_sat;
  logic [ZQ_W-2:0]       qz;
  always_comb begin
    q = dvd;
    if (neg) begin
      q_sat = (q > DIVIDEND_W'(32768)) ? 16'sh8000 : $signed(16'(~q[15:0] + 16'd1));
    end else begin
      q_sat = (q > DIVIDEND_W'(32767)) ? 16'sh7fff : $signed(q[15:0]);
    end
    qz = (q > DIVIDEND_W'(ZQ_LIMIT)) ? ZQ_LIMIT : q[ZQ_W-2:0];
  end

  // Neighbor coordinates and bounds.
  logic signed [16:0] nx, ny;
  logic               nb_on;
  logic               nb_last;
  always_comb begin
    nx = 17'(sx) + 17'(nb_dx) - 17'sd1;
    ny = 17'(sy) + 17'(nb_dy) - 17'sd1;
    nb_on = !nx[16] && (nx < $signed(17'(SCREEN_WIDTH))) &&
            !ny[16] && (ny < $signed(17'(SCREEN_HEIGHT)));
    nb_last = (nb_dx == 2'd2) && (nb_dy == 2'd2);
  end

  // Depth compare.
  logic signed [19:0] diff;
  logic [19:0]        diff_abs;
  logic               match;
  always_comb begin
    diff     = $signed({4'd0, ram_rd_data}) - 20'(zq);
    diff_abs = diff[19] ? 20'(-diff) : 20'(diff);
    match    = diff_abs <= DEPTH_TOL;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (in_item.action == ACT_TEST)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:    state_next = ST_ACC;
      ST_ACC:    state_next = (row == 2'd3 && col == 2'd2) ? ST_CHECKW : ST_MUL;
      ST_CHECKW: state_next = (clip[3] == '0) ? ST_DONE : ST_NUM;
      ST_NUM:    state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DCNT_W'(DIVIDEND_W - 1)) begin
          state_next = ST_POST;
        end
      end
      ST_POST:   state_next = (div_sel == 2'd2) ? ST_NB : ST_NUM;
      ST_NB: begin
        if (nb_on) begin
          state_next = ST_CMP;
        end else if (nb_last) begin
          state_next = ST_DONE;
        end
      end
      ST_CMP:    state_next = (match || nb_last) ? ST_DONE : ST_NB;
      ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_addr = ADDR_W'(ADDR_W'(in_item.pixel_y) * ADDR_W'(SCREEN_WIDTH) +
                          ADDR_W'(in_item.pixel_x));
    ram_rd_addr = ADDR_W'(ADDR_W'(ny[YW-1:0]) * ADDR_W'(SCREEN_WIDTH) +
                          ADDR_W'(nx[XW-1:0]));
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_wr_en = in_valid && (in_item.action == ACT_LOAD) && pixel_ok;
      end
      ST_NB:   ram_rd_en = nb_on;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  dbvv_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_depth_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(in_item.depth_value),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Matrix registers, written by the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= '0;
      end
    end else if (cfg_write) begin
      mat[{cfg_index, 1'b0}] <= $signed(cfg_data[31:0]);
      mat[{cfg_index, 1'b1}] <= $signed(cfg_data[63:32]);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        vx      <= in_item.vertex_x;
        vy      <= in_item.vertex_y;
        vz      <= in_item.vertex_z;
        row     <= 2'd0;
        col     <= 2'd0;
        div_sel <= 2'd0;
        sx      <= '0;
        sy      <= '0;
        zq      <= '0;
        wd      <= '0;
        visible <= 1'b0;
        outside <= 1'b1;
        nb_dx   <= 2'd0;
        nb_dy   <= 2'd0;
        for (int r = 0; r < 4; r++) begin
          clip[r] <= CLIP_W'(mat[r * 4 + 3]);
        end
      end
      ST_MUL: prod <= mul_a * mul_b;
      ST_ACC: begin
        clip[row] <= clip[row] + CLIP_W'(term);
        if (col == 2'd2) begin
          col <= 2'd0;
          row <= row + 2'd1;
        end else begin
          col <= col + 2'd1;
        end
      end
      ST_NUM: begin
        neg <= num_sum[NUM_W-1] ^ clip[3][CLIP_W-1];
        num <= num_sum[NUM_W-1] ? NUM_W'(-num_sum) : NUM_W'(num_sum);
        den <= clip[3][CLIP_W-1] ? DEN_W'({-clip[3], 1'b0}) : DEN_W'({clip[3], 1'b0});
      end
      ST_SCALE: begin
        dvd     <= DIVIDEND_W'(num) * DIVIDEND_W'(scale);
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem     <= qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        dvd     <= {dvd[DIVIDEND_W-2:0], qbit};
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      ST_POST: begin
        div_sel <= div_sel + 2'd1;
        case (div_sel)
          2'd0: sx <= q_sat;
          2'd1: sy <= q_sat;
          default: begin
            zq <= neg ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
            if (neg) begin
              wd <= '0;
            end else if (qz > 18'd65535) begin
              wd <= 16'hFFFF;
            end else begin
              wd <= qz[15:0];
            end
          end
        endcase
      end
      ST_NB: begin
        if (nb_on) begin
          outside <= 1'b0;
        end else if (nb_dy == 2'd2) begin
          nb_dy <= 2'd0;
          nb_dx <= nb_dx + 2'd1;
        end else begin
          nb_dy <= nb_dy + 2'd1;
        end
      end
      ST_CMP: begin
        if (match) begin
          visible <= 1'b1;
        end else if (nb_dy == 2'd2) begin
          nb_dy <= 2'd0;
          nb_dx <= nb_dx + 2'd1;
        end else begin
          nb_dy <= nb_dy + 2'd1;
        end
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

  // Counters and the output register.
  logic [CNT_W-1:0] visible_inc, outside_inc;
  assign visible_inc = (visible && visible_count != COUNTER_MAX) ?
                       visible_count + CNT_W'(1) : visible_count;
  assign outside_inc = (outside && outside_count != COUNTER_MAX) ?
                       outside_count + CNT_W'(1) : outside_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      visible_count <= '0;
      outside_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire && (in_item.action == ACT_CLEAR)) begin
        visible_count <= '0;
        outside_count <= '0;
      end
      if (state == ST_DONE && out_free) begin
        visible_count           <= visible_inc;
        outside_count           <= outside_inc;
        out_valid               <= 1'b1;
        out_item.is_visible     <= visible;
        out_item.is_outside     <= outside;
        out_item.screen_x       <= sx;
        out_item.screen_y       <= sy;
        out_item.window_depth   <= wd;
        out_item.visible_total  <= visible_inc;
        out_item.outside_total  <= outside_inc;
      end
    end
  end

  // Checks on the sequencer and results.
  a_not_both: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.is_visible && out_item.is_outside))
    else $error("result both visible and outside");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> $past(state) == ST_NB)
    else $error("compare without a depth read");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt < DCNT_W'(DIVIDEND_W))
    else $error("divider ran past its step count");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result issued outside the done state");

endmodule

`default_nettype wire
